[hdl/wia_pkg.sv]
// ----------------------------------------------------------------------------
// wia_pkg
// shared types, operation codes and helpers for the 128-bit integer alu
// ----------------------------------------------------------------------------
package wia_pkg;

	localparam int WORD_BITS = 128;
	localparam int DIV_STEPS = WORD_BITS;
	// input register, one stage per quotient bit, then the sign fix stage
	localparam int LAST_STAGE = DIV_STEPS + 2;

	localparam logic [3:0] FUNC_ADD = 4'd0;
	localparam logic [3:0] FUNC_SUB = 4'd1;
	localparam logic [3:0] FUNC_MUL = 4'd2;
	localparam logic [3:0] FUNC_DIV = 4'd3;
	localparam logic [3:0] FUNC_REM = 4'd4;
	localparam logic [3:0] FUNC_AND = 4'd5;
	localparam logic [3:0] FUNC_OR  = 4'd6;
	localparam logic [3:0] FUNC_XOR = 4'd7;
	localparam logic [3:0] FUNC_NOT = 4'd8;
	localparam logic [3:0] FUNC_SHL = 4'd9;
	localparam logic [3:0] FUNC_SHR = 4'd10;
	localparam logic [3:0] FUNC_CMP = 4'd11;
	localparam logic [3:0] FUNC_NEG = 4'd12;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [3:0]  func;
		logic [63:0] a_low;
		logic [63:0] a_high;
		logic [63:0] b_low;
		logic [63:0] b_high;
		logic [7:0]  shift_amount;
	} op_t;

	typedef struct packed {
		logic [63:0] result_low;
		logic [63:0] result_high;
		logic        less_than;
		logic        equal;
		logic        greater_than;
		logic        divide_by_zero;
	} res_t;

	// partial remainder, dividend bits shifting out / quotient bits shifting in
	typedef struct packed {
		word_t rem;
		word_t quo;
		word_t den;
	} div_t;

	typedef struct packed {
		logic [3:0] func;
		word_t      res;
		logic       lt;
		logic       eq;
		logic       gt;
		logic       dz;
		logic       na;
		logic       nb;
		div_t       dv;
	} stage_t;

	function automatic word_t neg_word(input word_t x);
		return ~x + word_t'(1);
	endfunction

endpackage

[hdl/wia_div_step.sv]
// ----------------------------------------------------------------------------
// wia_div_step
// one restoring step of the unsigned magnitude divider
// ----------------------------------------------------------------------------
module wia_div_step (
	input  wia_pkg::div_t cur,
	output wia_pkg::div_t nxt
);

	wia_pkg::word_t                 shifted;
	logic [wia_pkg::WORD_BITS:0]    diff;
	logic                           take;

	always_comb begin
		shifted = {cur.rem[wia_pkg::WORD_BITS-2:0], cur.quo[wia_pkg::WORD_BITS-1]};
		diff    = {cur.rem[wia_pkg::WORD_BITS-1], shifted} - {1'b0, cur.den};
		take    = ~diff[wia_pkg::WORD_BITS];
		nxt.den = cur.den;
		nxt.quo = {cur.quo[wia_pkg::WORD_BITS-2:0], take};
		nxt.rem = take ? diff[wia_pkg::WORD_BITS-1:0] : shifted;
	end

endmodule

[hdl/wide_integer_alu_128_unit.sv]
// ----------------------------------------------------------------------------
// wide_integer_alu_128_unit
// fully pipelined 128-bit integer alu with signed divide and remainder
// ----------------------------------------------------------------------------
// usage:
//   op channel (op_valid / op_stall / op) takes one beat per cycle: the
//   operation code, both 128-bit operands and a shift count
//   res channel (res_valid / res_stall / res) gives one beat per op beat,
//   in order: the result words, the compare flags and the zero-divisor flag
//   every operation passes through 130 register stages (one input stage,
//   one per quotient bit of the 128-step divider, one sign-fix stage); the divider
//   chain sets that depth, all other operations ride along with it
//   throughput is one beat per cycle unless stalled, every operation mixes freely
//   the multiplier uses ten 32x32 products (stage 1), column sums
//   (stage 2) and a final add (stage 3)
//   when res_stall is high with a beat waiting, the whole pipe holds and
//   op_stall goes high in the same cycle; nothing is lost or repeated
//   reset clears all stage valid bits, the pipe starts empty
// ----------------------------------------------------------------------------
module wide_integer_alu_128_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_stall,
	input  wia_pkg::op_t  op,
	output logic          res_valid,
	input  logic          res_stall,
	output wia_pkg::res_t res
);

	// pipe advances unless the output beat is held
	logic advance;

	logic             vld_s [1:wia_pkg::LAST_STAGE];
	wia_pkg::stage_t  st_s  [1:wia_pkg::LAST_STAGE];

	// multiplier partial products and column sums
	logic [63:0]      prod_s1 [0:9];
	logic [65:0]      col_s2  [0:3];

	wia_pkg::word_t   a_in;
	wia_pkg::word_t   b_in;
	wia_pkg::stage_t  first;

	assign advance  = ~(vld_s[wia_pkg::LAST_STAGE] & res_stall);
	assign op_stall = ~advance;

	// ---------------------------------------------------------------- stage 1
	always_comb begin
		a_in = {op.a_high, op.a_low};
		b_in = {op.b_high, op.b_low};
		first        = '0;
		first.func   = op.func;
		first.na     = a_in[wia_pkg::WORD_BITS-1];
		first.nb     = b_in[wia_pkg::WORD_BITS-1];
		// magnitudes; the most negative value maps onto 2^127 as wanted
		first.dv.rem = '0;
		first.dv.quo = first.na ? wia_pkg::neg_word(a_in) : a_in;
		first.dv.den = first.nb ? wia_pkg::neg_word(b_in) : b_in;
		case (op.func)
			wia_pkg::FUNC_ADD: first.res = a_in + b_in;
			wia_pkg::FUNC_SUB: first.res = a_in - b_in;
			wia_pkg::FUNC_AND: first.res = a_in & b_in;
			wia_pkg::FUNC_OR:  first.res = a_in | b_in;
			wia_pkg::FUNC_XOR: first.res = a_in ^ b_in;
			wia_pkg::FUNC_NOT: first.res = ~a_in;
			wia_pkg::FUNC_SHL: first.res = op.shift_amount[7] ? '0 : a_in << op.shift_amount[6:0];
			wia_pkg::FUNC_SHR: first.res = op.shift_amount[7] ? '0 : a_in >> op.shift_amount[6:0];
			wia_pkg::FUNC_NEG: first.res = wia_pkg::neg_word(a_in);
			wia_pkg::FUNC_CMP: begin
				first.lt = a_in < b_in;
				first.eq = a_in == b_in;
				first.gt = a_in > b_in;
			end
			wia_pkg::FUNC_DIV, wia_pkg::FUNC_REM: first.dz = b_in == '0;
			default: first.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (advance) begin
			vld_s[1] <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s[1]    <= first;
			// low 128 bits of the product need only limb pairs i+j <= 3
			prod_s1[0] <= op.a_low[31:0]  * op.b_low[31:0];
			prod_s1[1] <= op.a_low[31:0]  * op.b_low[63:32];
			prod_s1[2] <= op.a_low[63:32] * op.b_low[31:0];
			prod_s1[3] <= op.a_low[31:0]  * op.b_high[31:0];
			prod_s1[4] <= op.a_low[63:32] * op.b_low[63:32];
			prod_s1[5] <= op.a_high[31:0] * op.b_low[31:0];
			prod_s1[6] <= op.a_low[31:0]  * op.b_high[63:32];
			prod_s1[7] <= op.a_low[63:32] * op.b_high[31:0];
			prod_s1[8] <= op.a_high[31:0] * op.b_low[63:32];
			prod_s1[9] <= op.a_high[63:32] * op.b_low[31:0];
		end
	end

	// ------------------------------------------------------- divider stages
	genvar k;
	generate
		for (k = 1; k <= wia_pkg::DIV_STEPS; k++) begin : g_step
			wia_pkg::div_t   dv_next;
			wia_pkg::stage_t st_next;

			wia_div_step u_step (
				.cur (st_s[k].dv),
				.nxt (dv_next)
			);

			always_comb begin
				st_next    = st_s[k];
				st_next.dv = dv_next;
				if (k == 2 && st_s[k].func == wia_pkg::FUNC_MUL) begin
					st_next.res = wia_pkg::word_t'(col_s2[0])
						+ (wia_pkg::word_t'(col_s2[1]) << 32)
						+ (wia_pkg::word_t'(col_s2[2]) << 64)
						+ (wia_pkg::word_t'(col_s2[3][31:0]) << 96);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (advance) begin
					vld_s[k+1] <= vld_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (advance) begin
					st_s[k+1] <= st_next;
				end
			end

			if (k == 1) begin : g_cols
				always_ff @(posedge clk) begin
					if (advance) begin
						col_s2[0] <= {2'b00, prod_s1[0]};
						col_s2[1] <= 66'(prod_s1[1]) + 66'(prod_s1[2]);
						col_s2[2] <= 66'(prod_s1[3]) + 66'(prod_s1[4]) + 66'(prod_s1[5]);
						col_s2[3] <= 66'(prod_s1[6]) + 66'(prod_s1[7])
							+ 66'(prod_s1[8]) + 66'(prod_s1[9]);
					end
				end
			end
		end
	endgenerate

	// ------------------------------------------------------- sign fix stage
	wia_pkg::stage_t pre;
	wia_pkg::stage_t fin;

	assign pre = st_s[wia_pkg::LAST_STAGE-1];

	always_comb begin
		fin = pre;
		case (pre.func)
			wia_pkg::FUNC_DIV: fin.res = (pre.na ^ pre.nb) ? wia_pkg::neg_word(pre.dv.quo)
				: pre.dv.quo;
			wia_pkg::FUNC_REM: fin.res = pre.na ? wia_pkg::neg_word(pre.dv.rem) : pre.dv.rem;
			default: fin.res = pre.res;
		endcase
		if (pre.dz) begin
			fin.res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[wia_pkg::LAST_STAGE] <= 1'b0;
		end else if (advance) begin
			vld_s[wia_pkg::LAST_STAGE] <= vld_s[wia_pkg::LAST_STAGE-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s[wia_pkg::LAST_STAGE] <= fin;
		end
	end

	// ---------------------------------------------------------------- output
	assign res_valid          = vld_s[wia_pkg::LAST_STAGE];
	assign res.result_low     = st_s[wia_pkg::LAST_STAGE].res[63:0];
	assign res.result_high    = st_s[wia_pkg::LAST_STAGE].res[127:64];
	assign res.less_than      = st_s[wia_pkg::LAST_STAGE].lt;
	assign res.equal          = st_s[wia_pkg::LAST_STAGE].eq;
	assign res.greater_than   = st_s[wia_pkg::LAST_STAGE].gt;
	assign res.divide_by_zero = st_s[wia_pkg::LAST_STAGE].dz;

endmodule

[hdl/wia_checker.sv]
// ----------------------------------------------------------------------------
// wia_checker
// port-level checks for the 128-bit integer alu
// ----------------------------------------------------------------------------
module wia_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          op_stall,
	input logic          res_valid,
	input logic          res_stall,
	input wia_pkg::res_t res
);

	// a held result beat stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("held result beat changed");

	// compare gives at most one relation
	a_cmp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0({res.less_than, res.equal, res.greater_than}))
		else $error("more than one compare flag");

	// zero divisor forces zero result and no compare flags
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.divide_by_zero |->
		res.result_low == '0 && res.result_high == '0 &&
		!res.less_than && !res.equal && !res.greater_than)
		else $error("zero divisor beat not cleared");

	// input only blocked while an output beat is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> res_valid && res_stall)
		else $error("input stalled without output backpressure");

endmodule

bind wide_integer_alu_128_unit wia_checker u_wia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.op_stall  (op_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

[bench/tb_wide_integer_alu_128_unit.sv]
// ----------------------------------------------------------------------------
// tb_wide_integer_alu_128_unit
// self-checking bench for the pipelined 128-bit alu: a directed corner set,
// then random operations with bursty input and a patterned output stall,
// each result compared field by field against an in-bench prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wide_integer_alu_128_unit;

	localparam int PIPE_DEPTH = 130;
	localparam int WATCHDOG = 20000;
	localparam int NUM_RANDOM = 1600;

	// predicted outcome of one alu beat, no hardware copied
	class alu_scoreboard;
		wia_pkg::res_t pending[$];
		int mismatches;

		function wia_pkg::word_t magnitude(wia_pkg::word_t x);
			return x[wia_pkg::WORD_BITS-1] ? (~x + 128'd1) : x;
		endfunction

		function wia_pkg::res_t compute(wia_pkg::op_t o);
			wia_pkg::res_t r;
			wia_pkg::word_t a, b, w, qa, qr;
			r = '0;
			w = '0;
			a = {o.a_high, o.a_low};
			b = {o.b_high, o.b_low};
			case (o.func)
				wia_pkg::FUNC_ADD: w = a + b;
				wia_pkg::FUNC_SUB: w = a - b;
				wia_pkg::FUNC_MUL: w = a * b;
				wia_pkg::FUNC_DIV, wia_pkg::FUNC_REM: begin
					if (b == '0) begin
						r.divide_by_zero = 1'b1;
					end else begin
						// magnitudes divide exactly; the most negative value stays 2^127
						qa = magnitude(a) / magnitude(b);
						qr = magnitude(a) % magnitude(b);
						if (o.func == wia_pkg::FUNC_DIV)
							w = (a[wia_pkg::WORD_BITS-1] != b[wia_pkg::WORD_BITS-1]) ?
								~qa + 128'd1 : qa;
						else
							w = a[wia_pkg::WORD_BITS-1] ? ~qr + 128'd1 : qr;
					end
				end
				wia_pkg::FUNC_AND: w = a & b;
				wia_pkg::FUNC_OR:  w = a | b;
				wia_pkg::FUNC_XOR: w = a ^ b;
				wia_pkg::FUNC_NOT: w = ~a;
				wia_pkg::FUNC_SHL: w = (o.shift_amount >= 8'd128) ? '0 : a << o.shift_amount;
				wia_pkg::FUNC_SHR: w = (o.shift_amount >= 8'd128) ? '0 : a >> o.shift_amount;
				wia_pkg::FUNC_CMP: begin
					r.less_than = a < b;
					r.equal = a == b;
					r.greater_than = a > b;
				end
				wia_pkg::FUNC_NEG: w = ~a + 128'd1;
				default: w = '0;
			endcase
			r.result_low = w[63:0];
			r.result_high = w[127:64];
			return r;
		endfunction

		function void note_op(wia_pkg::op_t o);
			pending.push_back(compute(o));
		endfunction

		function void check_result(wia_pkg::res_t got);
			wia_pkg::res_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got.result_low !== exp.result_low || got.result_high !== exp.result_high ||
					got.less_than !== exp.less_than || got.equal !== exp.equal ||
					got.greater_than !== exp.greater_than ||
					got.divide_by_zero !== exp.divide_by_zero) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %h_%h lt%b eq%b gt%b dz%b  got %h_%h lt%b eq%b gt%b dz%b",
						exp.result_high, exp.result_low, exp.less_than, exp.equal,
						exp.greater_than, exp.divide_by_zero, got.result_high, got.result_low,
						got.less_than, got.equal, got.greater_than, got.divide_by_zero);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	wia_pkg::op_t op = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	wia_pkg::res_t res;

	alu_scoreboard board = new();
	int idle_cycles = 0;
	bit long_hold = 1'b0;	// sender asks for the long receiver hold-off
	bit driving_done = 1'b0;

	wide_integer_alu_128_unit dut (
		.clk(clk), .arst_n(arst_n), .op_valid(op_valid), .op_stall(op_stall), .op(op),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// scoreboard hooks and the no-progress watchdog, all at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (op_valid && !op_stall) board.note_op(op);
			if (res_valid && !res_stall) board.check_result(res);
			if ((op_valid && !op_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: random stall pattern, plus one long hold-off when asked
	initial begin : receiver
		int k;
		bit hold_done;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				res_stall <= 1'b1;
				for (k = 0; k < 400; k++) @(negedge clk);
				hold_done = 1'b1;
				res_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 3))
					0: res_stall <= 1'($urandom_range(0, 1));  // choppy
					1: res_stall <= ($urandom_range(0, 9) == 0);
					default: res_stall <= 1'b0;
				endcase
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// wide operands biased toward edge values so carries and signs get hit
	function automatic logic [63:0] edge64();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7fff_ffff_ffff_ffff;
			4: return 64'(int'($urandom_range(0, 15)));
			default: return rand64();
		endcase
	endfunction

	// one beat: present at the falling edge, hold until taken at a rising edge
	task automatic send_beat(input wia_pkg::op_t o);
		op_valid <= 1'b1;
		op <= o;
		do @(posedge clk); while (op_stall);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		op_valid <= 1'b0;
	endtask

	function automatic wia_pkg::op_t make_op(logic [3:0] f, logic [127:0] a,
			logic [127:0] b, logic [7:0] s);
		wia_pkg::op_t o;
		o.func = f;
		o.a_low = a[63:0];
		o.a_high = a[127:64];
		o.b_low = b[63:0];
		o.b_high = b[127:64];
		o.shift_amount = s;
		return o;
	endfunction

	initial begin : sender
		logic [127:0] MINV, ONES;
		wia_pkg::op_t o;
		int n, burst, f, wait_cycles;
		bit hold_asked, drain_done;
		MINV = {1'b1, 127'd0};
		ONES = '1;
		hold_asked = 1'b0;
		drain_done = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corners: every op, division signs, zero divisor, big shifts
		send_beat(make_op(wia_pkg::FUNC_ADD, ONES, 128'd1, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_SUB, 128'd0, 128'd1, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_MUL, ONES, ONES, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_DIV, MINV, ONES, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_REM, MINV, ONES, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_DIV, 128'd7, 128'd0, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_REM, 128'd7, 128'd0, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_DIV, -128'sd7, 128'd2, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_REM, -128'sd7, 128'd2, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_REM, 128'd7, -128'sd2, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_DIV, MINV, MINV, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_AND, ONES, MINV, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_OR, 128'd0, MINV, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_XOR, ONES, ONES, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_NOT, 128'd0, ONES, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_SHL, ONES, 128'd0, 8'd127));
		send_beat(make_op(wia_pkg::FUNC_SHR, ONES, 128'd0, 8'd128));
		send_beat(make_op(wia_pkg::FUNC_SHL, ONES, 128'd0, 8'd255));
		send_beat(make_op(wia_pkg::FUNC_SHR, MINV, 128'd0, 8'd64));
		send_beat(make_op(wia_pkg::FUNC_CMP, ONES, 128'd1, 8'd5));
		send_beat(make_op(wia_pkg::FUNC_CMP, MINV, MINV, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_CMP, 128'd1, ONES, 8'd0));
		send_beat(make_op(wia_pkg::FUNC_NEG, MINV, 128'd0, 8'd0));
		send_beat(make_op(4'd13, ONES, ONES, 8'd3));
		send_beat(make_op(4'd15, ONES, ONES, 8'd200));

		// sender pause until the pipe drains completely
		pause_sender();
		while (board.pending.size() != 0) @(negedge clk);

		n = 0;
		while (n < NUM_RANDOM) begin
			if (n >= 600 && !hold_asked) begin
				// fill the pipe against a held receiver
				long_hold = 1'b1;
				hold_asked = 1'b1;
			end
			if (n >= 1100 && !drain_done) begin
				drain_done = 1'b1;
				pause_sender();
				while (board.pending.size() != 0) @(negedge clk);
			end
			burst = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 60);
			repeat (burst) begin
				f = $urandom_range(0, 15);
				o.func = (f > 12 && $urandom_range(0, 3) != 0) ? wia_pkg::FUNC_DIV : 4'(f);
				o.a_low = edge64();
				o.a_high = edge64();
				o.b_low = edge64();
				o.b_high = edge64();
				o.shift_amount = 8'($urandom_range(0, 255));
				send_beat(o);
				n++;
			end
			wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (wait_cycles != 0) begin
				pause_sender();
				repeat (wait_cycles) @(negedge clk);
			end
		end
		pause_sender();
		driving_done = 1'b1;
	end

	initial begin : finisher
		wait (driving_done);
		while (board.pending.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 20) @(negedge clk);
		if (board.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
